// ===== hw/rtl/wfba_pkg.sv =====
// shared types and codes for the worst-fit block allocator
`timescale 1ns / 1ps

package wfba_pkg;

   // result status codes
   typedef enum logic [2:0] {
      STATUS_GRANTED  = 3'd0,
      STATUS_NO_FIT   = 3'd1,
      STATUS_ADDED    = 3'd2,
      STATUS_BAD_SIZE = 3'd3,
      STATUS_FULL     = 3'd4
   } status_type;

   // command codes
   localparam logic CMD_APPEND  = 1'b0;
   localparam logic CMD_REQUEST = 1'b1;

   // register index, taken from address bit 2
   localparam logic REG_SPLIT_MODE   = 1'b0;
   localparam logic REG_TOTAL_MEMORY = 1'b1;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic       SPLIT_MODE_RESET   = 1'b0;
   localparam logic [15:0] TOTAL_MEMORY_RESET = 16'hFFFF;

   typedef struct packed {
      logic        command;
      logic [15:0] amount;
      logic        occupied;
      logic [7:0]  process_id;
   } item_type;

   typedef struct packed {
      logic        split_mode;
      logic [15:0] total_memory;
   } cfg_type;

   typedef struct packed {
      logic [15:0] start;
      logic [15:0] size;
      logic        owned;
      logic [7:0]  owner;
      logic [15:0] used;
   } entry_type;

   typedef struct packed {
      status_type  status;
      logic [3:0]  block_index;
      logic [15:0] block_start;
      logic [15:0] block_end;
      logic [15:0] wasted;
      logic [15:0] total_waste;
   } result_type;

endpackage

// ===== hw/rtl/wfba_ram.sv =====
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module wfba_ram #(
   parameter int WIDTH = 57,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/wfba_core.sv =====
// allocator sequencer: table scan with one fit compare, split shift and table writes
`timescale 1ns / 1ps

module wfba_core #(
   parameter int MAX_BLOCKS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  wfba_pkg::item_type  req_item,
   input  wfba_pkg::cfg_type   cfg,
   output logic                res_valid,
   output wfba_pkg::result_type res,
   input  logic                res_take
);

   localparam int IDX_W = $clog2(MAX_BLOCKS);
   localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
   localparam int ENT_W = $bits(wfba_pkg::entry_type);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_SHIFT,
      S_WR_REM,
      S_WR_BEST,
      S_DONE
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [15:0]          layout_end_ff, layout_end_in;
   logic [15:0]          waste_ff, waste_in;
   logic [15:0]          amount_ff, amount_in;
   logic [7:0]           pid_ff, pid_in;
   logic [CNT_W-1:0]     ptr_ff, ptr_in;
   logic                 pend_ff, pend_in;
   logic [IDX_W-1:0]     pend_idx_ff, pend_idx_in;
   logic                 found_ff, found_in;
   logic [IDX_W-1:0]     best_idx_ff, best_idx_in;
   logic [15:0]          best_size_ff, best_size_in;
   logic [15:0]          best_start_ff, best_start_in;
   wfba_pkg::result_type res_ff, res_in;

   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   wfba_pkg::entry_type  wr_entry;
   logic [IDX_W-1:0]     rd_addr;
   logic [ENT_W-1:0]     rd_data;
   wfba_pkg::entry_type  rd_entry;

   logic                 accept;
   logic [16:0]          append_sum;
   logic                 issue;
   logic                 fit;
   logic [IDX_W+3:0]     count_ext;
   logic [IDX_W+3:0]     best_ext;

   assign rd_entry  = wfba_pkg::entry_type'(rd_data);
   assign accept    = req_valid && (state_ff == S_IDLE);
   assign req_stall = (state_ff != S_IDLE);
   assign append_sum = {1'b0, layout_end_ff} + {1'b0, req_item.amount};
   assign count_ext = {4'd0, count_ff[IDX_W-1:0]};
   assign best_ext  = {4'd0, best_idx_ff};

   // the fit compare, used by the table scan
   assign fit = pend_ff && !rd_entry.owned && (rd_entry.size >= amount_ff) &&
                (!found_ff || (rd_entry.size > best_size_ff));

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      layout_end_in = layout_end_ff;
      waste_in      = waste_ff;
      amount_in     = amount_ff;
      pid_in        = pid_ff;
      ptr_in        = ptr_ff;
      pend_in       = 1'b0;
      pend_idx_in   = pend_idx_ff;
      found_in      = found_ff;
      best_idx_in   = best_idx_ff;
      best_size_in  = best_size_ff;
      best_start_in = best_start_ff;
      res_in        = res_ff;
      wr_en         = 1'b0;
      wr_addr       = count_ff[IDX_W-1:0];
      wr_entry      = '0;
      rd_addr       = ptr_ff[IDX_W-1:0];
      issue         = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               amount_in = req_item.amount;
               pid_in    = req_item.process_id;
               res_in    = '0;
               if (req_item.command == wfba_pkg::CMD_APPEND) begin
                  state_in = S_DONE;
                  if ((req_item.amount == 16'd0) ||
                      (append_sum > {1'b0, cfg.total_memory})) begin
                     res_in.status = wfba_pkg::STATUS_BAD_SIZE;
                  end else if (count_ff >= CNT_W'(MAX_BLOCKS)) begin
                     res_in.status = wfba_pkg::STATUS_FULL;
                  end else begin
                     wr_en          = 1'b1;
                     wr_addr        = count_ff[IDX_W-1:0];
                     wr_entry.start = layout_end_ff;
                     wr_entry.size  = req_item.amount;
                     wr_entry.owned = req_item.occupied;
                     wr_entry.owner = req_item.occupied ? req_item.process_id : 8'd0;
                     wr_entry.used  = req_item.occupied ? req_item.amount : 16'd0;
                     count_in       = count_ff + CNT_W'(1);
                     layout_end_in  = append_sum[15:0];
                     res_in.status      = wfba_pkg::STATUS_ADDED;
                     res_in.block_index = count_ext[3:0];
                     res_in.block_start = layout_end_ff;
                     res_in.block_end   = append_sum[15:0];
                  end
               end else if (req_item.amount == 16'd0) begin
                  state_in      = S_DONE;
                  res_in.status = wfba_pkg::STATUS_BAD_SIZE;
               end else begin
                  state_in = S_SCAN;
                  ptr_in   = '0;
                  found_in = 1'b0;
               end
            end
         end

         S_SCAN: begin
            // reads go out one a cycle, the compare works on each read in the cycle after it
            issue       = (ptr_ff < count_ff);
            rd_addr     = ptr_ff[IDX_W-1:0];
            pend_in     = issue;
            pend_idx_in = ptr_ff[IDX_W-1:0];
            if (issue) begin
               ptr_in = ptr_ff + CNT_W'(1);
            end
            if (fit) begin
               found_in      = 1'b1;
               best_idx_in   = pend_idx_ff;
               best_size_in  = rd_entry.size;
               best_start_in = rd_entry.start;
            end
            if (!issue && !pend_ff) begin
               state_in = S_DECIDE;
            end
         end

         S_DECIDE: begin
            res_in = '0;
            if (!found_ff) begin
               state_in      = S_DONE;
               res_in.status = wfba_pkg::STATUS_NO_FIT;
            end else if (!cfg.split_mode) begin
               // fixed partition: whole block granted
               state_in       = S_DONE;
               wr_en          = 1'b1;
               wr_addr        = best_idx_ff;
               wr_entry.start = best_start_ff;
               wr_entry.size  = best_size_ff;
               wr_entry.owned = 1'b1;
               wr_entry.owner = pid_ff;
               wr_entry.used  = amount_ff;
               waste_in       = waste_ff + (best_size_ff - amount_ff);
               res_in.status      = wfba_pkg::STATUS_GRANTED;
               res_in.block_index = best_ext[3:0];
               res_in.block_start = best_start_ff;
               res_in.block_end   = best_start_ff + best_size_ff;
               res_in.wasted      = best_size_ff - amount_ff;
            end else if (best_size_ff > amount_ff) begin
               if (count_ff >= CNT_W'(MAX_BLOCKS)) begin
                  state_in      = S_DONE;
                  res_in.status = wfba_pkg::STATUS_FULL;
               end else begin
                  state_in = S_SHIFT;
                  ptr_in   = count_ff - CNT_W'(1);
               end
            end else begin
               state_in = S_WR_BEST;
            end
         end

         S_SHIFT: begin
            // move entries above best up by one, top first
            issue       = (ptr_ff > CNT_W'(best_idx_ff));
            rd_addr     = ptr_ff[IDX_W-1:0];
            pend_in     = issue;
            pend_idx_in = ptr_ff[IDX_W-1:0];
            if (issue) begin
               ptr_in = ptr_ff - CNT_W'(1);
            end
            if (pend_ff) begin
               wr_en    = 1'b1;
               wr_addr  = pend_idx_ff + IDX_W'(1);
               wr_entry = rd_entry;
            end
            if (!issue && !pend_ff) begin
               state_in = S_WR_REM;
            end
         end

         S_WR_REM: begin
            wr_en          = 1'b1;
            wr_addr        = best_idx_ff + IDX_W'(1);
            wr_entry.start = best_start_ff + amount_ff;
            wr_entry.size  = best_size_ff - amount_ff;
            count_in       = count_ff + CNT_W'(1);
            state_in       = S_WR_BEST;
         end

         S_WR_BEST: begin
            wr_en          = 1'b1;
            wr_addr        = best_idx_ff;
            wr_entry.start = best_start_ff;
            wr_entry.size  = amount_ff;
            wr_entry.owned = 1'b1;
            wr_entry.owner = pid_ff;
            wr_entry.used  = amount_ff;
            res_in             = '0;
            res_in.status      = wfba_pkg::STATUS_GRANTED;
            res_in.block_index = best_ext[3:0];
            res_in.block_start = best_start_ff;
            res_in.block_end   = best_start_ff + amount_ff;
            state_in           = S_DONE;
         end

         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         layout_end_ff <= '0;
         waste_ff      <= '0;
         pend_ff       <= 1'b0;
         found_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         layout_end_ff <= layout_end_in;
         waste_ff      <= waste_in;
         pend_ff       <= pend_in;
         found_ff      <= found_in;
      end
      amount_ff     <= amount_in;
      pid_ff        <= pid_in;
      ptr_ff        <= ptr_in;
      pend_idx_ff   <= pend_idx_in;
      best_idx_ff   <= best_idx_in;
      best_size_ff  <= best_size_in;
      best_start_ff <= best_start_in;
      res_ff        <= res_in;
   end

   wfba_ram #(
      .WIDTH (ENT_W),
      .DEPTH (MAX_BLOCKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (ENT_W'(wr_entry)),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign res_valid = (state_ff == S_DONE);

   always_comb begin
      res             = res_ff;
      res.total_waste = waste_ff;
   end

endmodule

// ===== hw/rtl/worst_fit_block_allocator_top.sv =====
// worst-fit block allocator top level: csr port, sequencer and result register
`timescale 1ns / 1ps

// channel  | ports             | beat
// ---------+-------------------+------------------------------------------
// request  | req_valid/stall   | command, amount, occupied, process_id
// response | rsp_valid/stall   | status, index, start, end, wasted, waste
// csr      | csr_psel/penable  | apb-style write/read, regs at 0x0 and 0x4
//
// an append beat is written from the idle state; a request scans the block
// table (one ram read a cycle), then a split with insert shifts the entries
// above the chosen block up and writes the remainder and the granted block,
// and an exact fit in variable mode writes only the granted block; reset
// clears the block count, layout end and waste sum and sets the csr registers
// to their reset values; table ram contents are not cleared, only entries
// below the count are read; a finished result sits in the response register,
// so the next request beat is taken while rsp_stall holds the previous one

module worst_fit_block_allocator_top #(
   parameter int MAX_BLOCKS = 16
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [15:0] req_amount,
   input  logic        req_occupied,
   input  logic [7:0]  req_process_id,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [3:0]  rsp_block_index,
   output logic [15:0] rsp_block_start,
   output logic [15:0] rsp_block_end,
   output logic [15:0] rsp_wasted,
   output logic [15:0] rsp_total_waste,

   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [wfba_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [wfba_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [wfba_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   // csr registers
   logic        split_mode_ff, split_mode_in;
   logic [15:0] total_memory_ff, total_memory_in;
   logic        csr_write;

   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   wfba_pkg::result_type rsp_ff, rsp_in;

   wfba_pkg::item_type   req_item;
   wfba_pkg::cfg_type    cfg;
   wfba_pkg::result_type res;
   logic                 res_valid;
   logic                 res_take;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      split_mode_in   = split_mode_ff;
      total_memory_in = total_memory_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            wfba_pkg::REG_SPLIT_MODE:   split_mode_in   = csr_pwdata[0];
            wfba_pkg::REG_TOTAL_MEMORY: total_memory_in = csr_pwdata[15:0];
            default: begin
               split_mode_in = split_mode_ff;
            end
         endcase
      end
   end

   // read mux, address bits below 2 ignored
   always_comb begin
      case (csr_paddr[2])
         wfba_pkg::REG_SPLIT_MODE:
            csr_prdata = {{(wfba_pkg::CSR_DATA_W-1){1'b0}}, split_mode_ff};
         wfba_pkg::REG_TOTAL_MEMORY:
            csr_prdata = {{(wfba_pkg::CSR_DATA_W-16){1'b0}}, total_memory_ff};
         default:
            csr_prdata = '0;
      endcase
   end

   assign cfg.split_mode   = split_mode_ff;
   assign cfg.total_memory = total_memory_ff;

   assign req_item.command    = req_command;
   assign req_item.amount     = req_amount;
   assign req_item.occupied   = req_occupied;
   assign req_item.process_id = req_process_id;

   wfba_core #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .cfg       (cfg),
      .res_valid (res_valid),
      .res       (res),
      .res_take  (res_take)
   );

   // result moves in whenever the response register is empty or draining
   assign res_take = res_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         split_mode_ff   <= wfba_pkg::SPLIT_MODE_RESET;
         total_memory_ff <= wfba_pkg::TOTAL_MEMORY_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         split_mode_ff   <= split_mode_in;
         total_memory_ff <= total_memory_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_ff.status;
   assign rsp_block_index = rsp_ff.block_index;
   assign rsp_block_start = rsp_ff.block_start;
   assign rsp_block_end   = rsp_ff.block_end;
   assign rsp_wasted      = rsp_ff.wasted;
   assign rsp_total_waste = rsp_ff.total_waste;

endmodule
